FILE: rtl/core/rcm_pkg.sv
package rcm_pkg;

   localparam int unsigned KeyLoW = 64;
   localparam int unsigned KeyHiW = 56;

   typedef enum logic [2:0] {
      CODE_JOINED  = 3'd0,
      CODE_NEW     = 3'd1,
      CODE_FULL    = 3'd2,
      CODE_DUP     = 3'd3,
      CODE_BADW    = 3'd4,
      CODE_MEMBER  = 3'd5,
      CODE_NONE    = 3'd6
   } code_type;

   typedef enum logic {
      FUNC_ADD   = 1'b0,
      FUNC_DRAIN = 1'b1
   } func_type;

   localparam logic [0:0] REG_WORKER_COUNT = 1'b0;

   typedef struct packed {
      logic              func;
      logic [3:0]        wrk;
      logic [3:0]        len;
      logic [KeyLoW-1:0] lo;
      logic [KeyHiW-1:0] hi;
      logic [7:0]        status;
      logic [3:0]        nd;
   } item_type;

   function automatic logic [KeyLoW-1:0] lo_mask(input logic [3:0] len);
      logic [KeyLoW-1:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (int'(len) > b) m[b*8 +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [KeyHiW-1:0] hi_mask(input logic [3:0] len,
                                                 input int unsigned key_bytes);
      logic [KeyHiW-1:0] m;
      m = '0;
      for (int b = 0; b < 7; b++) begin
         if (int'(len) > b + 8 && key_bytes > b + 8) m[b*8 +: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic [KeyLoW-1:0] lo_mask_k(input logic [3:0] len,
                                                   input int unsigned key_bytes);
      logic [KeyLoW-1:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (int'(len) > b && key_bytes > b) m[b*8 +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage

FILE: rtl/core/rcm_ram.sv
module rcm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rcm_front.sv
module rcm_front #(
   parameter int unsigned KEY_BYTES = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [2:0]        req_worker,
   input  logic [3:0]        req_insn_len,
   input  logic [63:0]       req_insn_lo,
   input  logic [55:0]       req_insn_hi,
   input  logic [7:0]        req_status,
   input  logic [3:0]        req_ndecoded,
   output rcm_pkg::item_type q_item,
   output logic              q_valid,
   input  logic              q_pop
);
   import rcm_pkg::*;

   localparam int unsigned Depth = 2;

   item_type   buf_ff [Depth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   it;

   always_comb begin
      it.func   = req_func;
      it.wrk    = {1'b0, req_worker};
      it.len    = req_insn_len;
      it.lo     = req_insn_lo & lo_mask_k(req_insn_len, KEY_BYTES);
      it.hi     = req_insn_hi & hi_mask(req_insn_len, KEY_BYTES);
      it.status = req_status;
      it.nd     = req_ndecoded;
   end

   assign req_stall = (cnt_ff == 2'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = buf_ff[rp_ff];
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = (q_pop && q_valid) ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(q_pop && q_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= it;
      end
   end

endmodule

FILE: rtl/core/rcm_back.sv
module rcm_back #(
   parameter int unsigned SLOTS   = 4,
   parameter int unsigned WORKERS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        worker_count,
   input  rcm_pkg::item_type q_item,
   input  logic              q_valid,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_code,
   output logic [1:0]        rsp_slot,
   output logic [2:0]        rsp_worker_res,
   output logic [7:0]        rsp_status_res,
   output logic [3:0]        rsp_ndecoded_res,
   output logic [3:0]        rsp_insn_len_res,
   output logic [63:0]       rsp_insn_lo_res,
   output logic [55:0]       rsp_insn_hi_res,
   output logic              rsp_last
);
   import rcm_pkg::*;

   localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned WBW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int unsigned MD  = SLOTS * WORKERS;
   localparam int unsigned MW  = (MD > 1) ? $clog2(MD) : 1;
   localparam int unsigned CW  = $clog2(WORKERS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FIND, ST_MREAD, ST_MEMIT, ST_OUT
   } state_type;

   state_type          state_ff;
   logic [WORKERS-1:0] mask_ff [SLOTS];
   logic [3:0]         klen_ff [SLOTS];
   logic [63:0]        klo_ff  [SLOTS];
   logic [55:0]        khi_ff  [SLOTS];
   item_type           cur_ff;
   logic [SW-1:0]      ds_ff;
   logic [WBW-1:0]     dw_ff;
   logic               emitted_ff;
   logic [SLOTS-1:0]   hit_ff, empty_ff, comp_ff;

   logic               o_valid_ff;
   logic [2:0]         o_code_ff;
   logic [1:0]         o_slot_ff;
   logic [2:0]         o_w_ff;
   logic [3:0]         o_len_ff;
   logic [63:0]        o_lo_ff;
   logic [55:0]        o_hi_ff;
   logic               o_last_ff;

   logic [CW-1:0]      eff;
   logic [WORKERS-1:0] full;
   logic               mem_we;
   logic [MW-1:0]      mem_wa, mem_ra;
   logic [11:0]        mem_rd;
   logic               out_free;
   logic               o_load;
   logic [11:0]        mem_rd_hold;
   logic [11:0]        hold_ff;

   always_comb begin
      eff = (int'(worker_count) < WORKERS) ? CW'(worker_count) : CW'(WORKERS);
      for (int i = 0; i < WORKERS; i++) full[i] = (i < int'(eff));
   end

   assign out_free = !o_valid_ff || !rsp_stall;
   assign o_load   = out_free && (state_ff == ST_MEMIT || state_ff == ST_OUT);
   assign mem_ra   = MW'(ds_ff * WORKERS + dw_ff);

   rcm_ram #(.WIDTH(12), .DEPTH(MD)) u_members (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data ({cur_ff.status, cur_ff.nd}),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   logic [SW-1:0] sel_hit, sel_empty;
   logic          any_hit, any_empty;
   always_comb begin
      sel_hit = '0;
      sel_empty = '0;
      any_hit = 1'b0;
      any_empty = 1'b0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (hit_ff[s]) begin
            sel_hit = SW'(s);
            any_hit = 1'b1;
         end
         if (empty_ff[s]) begin
            sel_empty = SW'(s);
            any_empty = 1'b1;
         end
      end
   end

   logic [SW-1:0] tgt;
   logic          bad;
   assign tgt = any_hit ? sel_hit : sel_empty;
   assign bad = cur_ff.wrk >= 4'(eff);
   always_comb begin
      mem_we = (state_ff == ST_OUT) && out_free && cur_ff.func == FUNC_ADD && !bad
               && (any_hit ? !mask_ff[sel_hit][cur_ff.wrk[WBW-1:0]] : any_empty);
      mem_wa = MW'(tgt * WORKERS + cur_ff.wrk[WBW-1:0]);
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         o_valid_ff <= 1'b0;
         for (int s = 0; s < SLOTS; s++) mask_ff[s] <= '0;
      end else begin
         o_valid_ff <= o_load || (o_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cur_ff     <= q_item;
                  ds_ff      <= '0;
                  dw_ff      <= '0;
                  emitted_ff <= 1'b0;
                  state_ff   <= ST_FIND;
               end
            end
            ST_FIND: begin
               for (int s = 0; s < SLOTS; s++) begin
                  hit_ff[s]   <= mask_ff[s] != '0 && klen_ff[s] == cur_ff.len &&
                                 klo_ff[s] == cur_ff.lo && khi_ff[s] == cur_ff.hi;
                  empty_ff[s] <= mask_ff[s] == '0;
                  comp_ff[s]  <= eff != '0 && mask_ff[s] == full;
               end
               state_ff <= (cur_ff.func == FUNC_ADD) ? ST_OUT : ST_MREAD;
            end
            ST_MREAD: begin
               if (comp_ff[ds_ff]) begin
                  state_ff <= ST_MEMIT;
               end else if (int'(ds_ff) == SLOTS - 1) begin
                  state_ff <= ST_OUT;
               end else begin
                  ds_ff <= ds_ff + 1'b1;
               end
            end
            ST_MEMIT: begin
               if (out_free) begin
                  o_code_ff  <= CODE_MEMBER;
                  o_slot_ff  <= 2'(ds_ff);
                  o_w_ff     <= 3'(dw_ff);
                  o_len_ff   <= klen_ff[ds_ff];
                  o_lo_ff    <= klo_ff[ds_ff];
                  o_hi_ff    <= khi_ff[ds_ff];
                  emitted_ff <= 1'b1;
                  if (int'(dw_ff) == int'(eff) - 1) begin
                     dw_ff <= '0;
                     mask_ff[ds_ff] <= '0;
                     comp_ff[ds_ff] <= 1'b0;
                     o_last_ff <= (comp_ff & ~(SLOTS'(1) << ds_ff)) == '0;
                     state_ff <= ((comp_ff & ~(SLOTS'(1) << ds_ff)) == '0) ? ST_IDLE
                                 : ST_MREAD;
                  end else begin
                     o_last_ff <= 1'b0;
                     dw_ff <= dw_ff + 1'b1;
                     state_ff <= ST_MREAD;
                  end
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  o_slot_ff  <= '0;
                  o_w_ff     <= '0;
                  o_len_ff   <= '0;
                  o_lo_ff    <= '0;
                  o_hi_ff    <= '0;
                  o_last_ff  <= 1'b1;
                  state_ff   <= ST_IDLE;
                  if (cur_ff.func == FUNC_DRAIN) begin
                     o_code_ff <= CODE_NONE;
                  end else if (bad) begin
                     o_code_ff <= CODE_BADW;
                  end else if (any_hit) begin
                     o_slot_ff <= 2'(sel_hit);
                     if (mask_ff[sel_hit][cur_ff.wrk[WBW-1:0]]) begin
                        o_code_ff <= CODE_DUP;
                     end else begin
                        o_code_ff <= CODE_JOINED;
                        mask_ff[sel_hit][cur_ff.wrk[WBW-1:0]] <= 1'b1;
                     end
                  end else if (any_empty) begin
                     o_code_ff <= CODE_NEW;
                     o_slot_ff <= 2'(sel_empty);
                     mask_ff[sel_empty] <= WORKERS'(1) << cur_ff.wrk[WBW-1:0];
                     klen_ff[sel_empty] <= cur_ff.len;
                     klo_ff[sel_empty]  <= cur_ff.lo;
                     khi_ff[sel_empty]  <= cur_ff.hi;
                  end else begin
                     o_code_ff <= CODE_FULL;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   logic emit_d_ff;
   always_ff @(posedge clock) begin
      if (reset) emit_d_ff <= 1'b0;
      else       emit_d_ff <= (state_ff == ST_MEMIT) && out_free;
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_code         = o_code_ff;
   assign rsp_slot         = o_slot_ff;
   assign rsp_worker_res   = o_w_ff;
   assign rsp_status_res   = (o_code_ff == CODE_MEMBER) ? mem_rd_hold[11:4] : 8'd0;
   assign rsp_ndecoded_res = (o_code_ff == CODE_MEMBER) ? mem_rd_hold[3:0] : 4'd0;
   assign rsp_insn_len_res = o_len_ff;
   assign rsp_insn_lo_res  = o_lo_ff;
   assign rsp_insn_hi_res  = o_hi_ff;
   assign rsp_last         = o_last_ff;

   always_ff @(posedge clock) begin
      if (emit_d_ff) hold_ff <= mem_rd;
   end
   assign mem_rd_hold = emit_d_ff ? mem_rd : hold_ff;

endmodule

FILE: rtl/core/result_cohort_matcher_unit.sv
// Channel | Direction | Handshake           | Beat
// req     | in        | req_valid/req_stall | one add or drain item
// rsp     | out       | rsp_valid/rsp_stall | one result
// csr     | in        | APB write/read      | worker_count at address 0
// An add item passes from the queue to its result in order: it is taken from the
// queue, all slot keys are compared in parallel, and then it commits and registers
// the result, which waits while the output is stalled.
// A drain visits each slot in turn and emits each member of a complete slot through
// the ST_MREAD and ST_MEMIT states, using the single read port of the member store.
// Reset clears the slot masks and the two-entry item queue at once.
// A stalled result holds the back end; the front keeps taking up to two items.
module result_cohort_matcher_unit #(
   parameter int unsigned SLOTS     = 4,
   parameter int unsigned WORKERS   = 8,
   parameter int unsigned KEY_BYTES = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [2:0]  req_worker,
   input  logic [3:0]  req_insn_len,
   input  logic [63:0] req_insn_lo,
   input  logic [55:0] req_insn_hi,
   input  logic [7:0]  req_status,
   input  logic [3:0]  req_ndecoded,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_code,
   output logic [1:0]  rsp_slot,
   output logic [2:0]  rsp_worker_res,
   output logic [7:0]  rsp_status_res,
   output logic [3:0]  rsp_ndecoded_res,
   output logic [3:0]  rsp_insn_len_res,
   output logic [63:0] rsp_insn_lo_res,
   output logic [55:0] rsp_insn_hi_res,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rcm_pkg::*;

   logic [3:0] wc_ff;
   item_type   q_item;
   logic       q_valid, q_pop;

   assign pready = 1'b1;
   assign prdata = (paddr[1] == REG_WORKER_COUNT) ? {28'd0, wc_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff <= 4'd8;
      end else if (psel && penable && pwrite && paddr[1] == REG_WORKER_COUNT) begin
         wc_ff <= pwdata[3:0];
      end
   end

   rcm_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_worker,
      .req_insn_len, .req_insn_lo, .req_insn_hi, .req_status, .req_ndecoded,
      .q_item, .q_valid, .q_pop
   );

   rcm_back #(.SLOTS(SLOTS), .WORKERS(WORKERS)) u_back (
      .clock, .reset, .worker_count(wc_ff), .q_item, .q_valid, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_code, .rsp_slot, .rsp_worker_res,
      .rsp_status_res, .rsp_ndecoded_res, .rsp_insn_len_res, .rsp_insn_lo_res,
      .rsp_insn_hi_res, .rsp_last
   );

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code != 3'd7)
      else $error("result code out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code) && $stable(rsp_last))
      else $error("stalled result changed");

   a_member_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code != CODE_MEMBER |-> rsp_last && rsp_insn_len_res == 4'd0)
      else $error("non-member result not final or carries a key");

endmodule
